// File: hw/rtl/rgb565_band_upscaler_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RGB565 band upscaler
// Short forms of the clocked properties used by the port checker.
// ---------------------------------------------------------------------------
`ifndef RGB565_BAND_UPSCALER_TOP_MACROS_SVH
`define RGB565_BAND_UPSCALER_TOP_MACROS_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define RBU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbu: implication failed");

// Condition in one cycle implies a consequence in the next cycle.
`define RBU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbu: next-cycle check failed");

// Condition in one cycle implies the signal holds its value into the next.
`define RBU_ASSERT_HOLD(lbl, ante, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> $stable(sig)) \
    else $error("rbu: value did not hold");

// Checked through reset: an asserted reset forces the consequence next cycle.
`define RBU_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("rbu: reset value wrong");

`endif

// File: hw/rtl/rbu_pkg.sv
// ---------------------------------------------------------------------------
// RGB565 band upscaler package
// Shared widths, register codes, work item type and pixel averaging helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package rbu_pkg;

  localparam int RUN_PIXELS = 6;
  localparam int OUT_PIXELS = 8;
  localparam int PIX_W      = 16;
  localparam int ROW_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF  = 2;

  // Per-channel floor average: drop each channel's low bit before adding,
  // then add back the carry when both low bits were set.
  localparam logic [PIX_W-1:0] AVG_MASK  = 16'hF7DE;
  localparam logic [PIX_W-1:0] AVG_CARRY = 16'h0821;

  localparam logic [ROW_W-1:0]      ROWS_MIN   = 2'd2;
  localparam logic [ROW_W-1:0]      ROWS_RESET = 2'd2;
  localparam logic [CFG_DATA_W-1:0] SEGS_RESET = 7'd40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_PER_BAND     = 1'b0,
    REG_SEGMENTS_PER_LINE = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [RUN_PIXELS-1:0] run_t;
  typedef pix_t [OUT_PIXELS-1:0] wide_t;

  // What the back end has to produce for one source run.
  typedef enum logic [1:0] {
    KIND_PLAIN,      // first row of a band: the run widened
    KIND_MIX,        // middle row: vertical average widened
    KIND_MIX_PLAIN   // last row: vertical average, then the run itself
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ROW_W-1:0]  band_row;
    run_t              cur;
    run_t              prior;
  } work_t;

  function automatic pix_t avg565(pix_t a, pix_t b);
    pix_t sum;
    sum = ((a & AVG_MASK) >> 1) + ((b & AVG_MASK) >> 1) + (a & b & AVG_CARRY);
    return sum;
  endfunction

  function automatic run_t mix_runs(run_t a, run_t b);
    run_t m;
    for (int i = 0; i < RUN_PIXELS; i++) begin
      m[i] = avg565(a[i], b[i]);
    end
    return m;
  endfunction

  // Six source pixels to eight: p0, a01, a12, p2, p3, a34, a45, p5.
  function automatic wide_t widen(run_t p);
    wide_t o;
    o[0] = p[0];
    o[1] = avg565(p[0], p[1]);
    o[2] = avg565(p[1], p[2]);
    o[3] = p[2];
    o[4] = p[3];
    o[5] = avg565(p[3], p[4]);
    o[6] = avg565(p[4], p[5]);
    o[7] = p[5];
    return o;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rbu_if.sv
// ---------------------------------------------------------------------------
// RGB565 band upscaler stream interfaces
// Valid/ready channels for source runs and for widened result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface rbu_in_if
  import rbu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in_0;
  logic [PIX_W-1:0] pixel_in_1;
  logic [PIX_W-1:0] pixel_in_2;
  logic [PIX_W-1:0] pixel_in_3;
  logic [PIX_W-1:0] pixel_in_4;
  logic [PIX_W-1:0] pixel_in_5;
  logic             start_of_frame;

  modport source (
    output valid, pixel_in_0, pixel_in_1, pixel_in_2, pixel_in_3, pixel_in_4,
           pixel_in_5, start_of_frame,
    input  ready
  );
  modport sink (
    input  valid, pixel_in_0, pixel_in_1, pixel_in_2, pixel_in_3, pixel_in_4,
           pixel_in_5, start_of_frame,
    output ready
  );
endinterface

interface rbu_out_if
  import rbu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out_0;
  logic [PIX_W-1:0] pixel_out_1;
  logic [PIX_W-1:0] pixel_out_2;
  logic [PIX_W-1:0] pixel_out_3;
  logic [PIX_W-1:0] pixel_out_4;
  logic [PIX_W-1:0] pixel_out_5;
  logic [PIX_W-1:0] pixel_out_6;
  logic [PIX_W-1:0] pixel_out_7;
  logic [ROW_W-1:0] dest_row;
  logic             last_of_run;

  modport source (
    output valid, pixel_out_0, pixel_out_1, pixel_out_2, pixel_out_3, pixel_out_4,
           pixel_out_5, pixel_out_6, pixel_out_7, dest_row, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, pixel_out_0, pixel_out_1, pixel_out_2, pixel_out_3, pixel_out_4,
           pixel_out_5, pixel_out_6, pixel_out_7, dest_row, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/rbu_front.sv
// ---------------------------------------------------------------------------
// RGB565 band upscaler front end
// Accepts runs, tracks run and band row, reads and rewrites the line store.
// ---------------------------------------------------------------------------
`default_nettype none

module rbu_front
  import rbu_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rbu_in_if.sink                in_ch,
  output logic                  push_valid,
  input  logic                  push_ready,
  output work_t                 push_work
);

  localparam int RUN_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = (RUN_W + 1 > CFG_DATA_W) ? RUN_W + 1 : CFG_DATA_W;
  localparam logic [CNT_W-1:0] SEG_MAX = CNT_W'(MAX_SEGMENTS);

  logic [ROW_W-1:0]      rows_r;
  logic [CFG_DATA_W-1:0] segs_r;
  logic [RUN_W-1:0]      run_r, run_nxt;
  logic [ROW_W-1:0]      band_r, band_nxt;

  logic [ROW_W-1:0] rpb;
  logic [CNT_W-1:0] spl_ext, spl;
  logic [RUN_W-1:0] run_cur;
  logic [RUN_W:0]   run_inc;
  logic [ROW_W-1:0] band_raw, band_cur, band_inc;
  logic             row_end;
  kind_t            kind_cur;
  logic             accept;
  run_t             cur_run;

  // Line store: one row of the previous source line per run, read-first.
  run_t             line_mem [MAX_SEGMENTS];
  run_t             prior_r;

  logic             s1_v_r;
  kind_t            s1_kind_r;
  logic [ROW_W-1:0] s1_band_r;
  run_t             s1_cur_r;

  assign cur_run = {in_ch.pixel_in_5, in_ch.pixel_in_4, in_ch.pixel_in_3,
                    in_ch.pixel_in_2, in_ch.pixel_in_1, in_ch.pixel_in_0};

  assign in_ch.ready = !s1_v_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    rpb      = (rows_r < ROWS_MIN) ? ROWS_MIN : rows_r;
    spl_ext  = CNT_W'(segs_r);
    if (spl_ext == '0) begin
      spl = CNT_W'(1);
    end else if (spl_ext > SEG_MAX) begin
      spl = SEG_MAX;
    end else begin
      spl = spl_ext;
    end

    run_cur  = in_ch.start_of_frame ? '0 : run_r;
    band_raw = in_ch.start_of_frame ? '0 : band_r;
    band_cur = (band_raw >= rpb) ? '0 : band_raw;
    band_inc = band_cur + 2'd1;

    if (band_cur == '0) begin
      kind_cur = KIND_PLAIN;
    end else if (band_inc >= rpb) begin
      kind_cur = KIND_MIX_PLAIN;
    end else begin
      kind_cur = KIND_MIX;
    end

    run_inc = {1'b0, run_cur} + (RUN_W+1)'(1);
    row_end = CNT_W'(run_inc) >= spl;
    if (row_end) begin
      run_nxt  = '0;
      band_nxt = (band_inc >= rpb) ? '0 : band_inc;
    end else begin
      run_nxt  = run_inc[RUN_W-1:0];
      band_nxt = band_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      segs_r <= SEGS_RESET;
      run_r  <= '0;
      band_r <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_ROWS_PER_BAND:     rows_r <= cfg_wdata[ROW_W-1:0];
          REG_SEGMENTS_PER_LINE: segs_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        run_r  <= run_nxt;
        band_r <= band_nxt;
        s1_v_r <= 1'b1;
      end else if (push_ready) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prior_r           <= line_mem[run_cur];
      line_mem[run_cur] <= cur_run;
      s1_kind_r         <= kind_cur;
      s1_band_r         <= band_cur;
      s1_cur_r          <= cur_run;
    end
  end

  assign push_valid = s1_v_r;
  always_comb begin
    push_work.kind     = s1_kind_r;
    push_work.band_row = s1_band_r;
    push_work.cur      = s1_cur_r;
    push_work.prior    = prior_r;
  end

endmodule

`default_nettype wire

// File: hw/rtl/rbu_queue.sv
// ---------------------------------------------------------------------------
// RGB565 band upscaler work queue
// Short FIFO of classified runs between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module rbu_queue
  import rbu_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_work,
  output logic  head_valid,
  input  logic  pop,
  output work_t head_work
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  work_t            slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_FULL;
  assign head_valid = count_r != '0;
  assign head_work  = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_work;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rbu_back.sv
// ---------------------------------------------------------------------------
// RGB565 band upscaler back end
// Widens queued runs and drives the registered result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module rbu_back
  import rbu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  head_valid,
  input  work_t head_work,
  output logic  pop,
  rbu_out_if.source out_ch
);

  logic             phase_r, phase_nxt;
  logic             out_v_r;
  wide_t            out_pix_r;
  logic [ROW_W-1:0] out_row_r;
  logic             out_last_r;

  run_t             mix_run;
  wide_t            res_pix;
  logic [ROW_W-1:0] res_row;
  logic             res_last;
  logic             res_pop;
  logic             load;

  assign mix_run = mix_runs(head_work.prior, head_work.cur);
  assign load    = head_valid && (!out_v_r || out_ch.ready);

  always_comb begin
    res_pix  = widen(head_work.cur);
    res_row  = head_work.band_row;
    res_last = 1'b1;
    res_pop  = 1'b1;
    case (head_work.kind)
      KIND_PLAIN: begin
        res_pix = widen(head_work.cur);
      end
      KIND_MIX: begin
        res_pix = widen(mix_run);
      end
      KIND_MIX_PLAIN: begin
        // The vertical average goes out first; the run itself follows on
        // the next row and retires the entry.
        if (!phase_r) begin
          res_pix  = widen(mix_run);
          res_last = 1'b0;
          res_pop  = 1'b0;
        end else begin
          res_row = head_work.band_row + 2'd1;
        end
      end
      default: begin
        res_pix = widen(head_work.cur);
      end
    endcase
    pop       = load && res_pop;
    phase_nxt = load ? !res_pop : phase_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pix_r  <= res_pix;
      out_row_r  <= res_row;
      out_last_r <= res_last;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.pixel_out_0 = out_pix_r[0];
  assign out_ch.pixel_out_1 = out_pix_r[1];
  assign out_ch.pixel_out_2 = out_pix_r[2];
  assign out_ch.pixel_out_3 = out_pix_r[3];
  assign out_ch.pixel_out_4 = out_pix_r[4];
  assign out_ch.pixel_out_5 = out_pix_r[5];
  assign out_ch.pixel_out_6 = out_pix_r[6];
  assign out_ch.pixel_out_7 = out_pix_r[7];
  assign out_ch.dest_row    = out_row_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/rgb565_band_upscaler_top.sv
// ---------------------------------------------------------------------------
// RGB565 band upscaler, top level
// 4:3 horizontal and band-based vertical upscaler for RGB565 pixel runs.
// ---------------------------------------------------------------------------
// Each input word carries one run of six source pixels, and each result word
// carries eight destination pixels with their row inside the band. A run on
// the first row of a band gives one word, a middle row gives one word (the
// vertical average with the previous row), and the band's last row gives two
// words, the average and then the run itself. Input words are taken one per
// cycle while the queue has room; the result channel moves one word per cycle
// while the receiver is ready, so a last-row input word needs two result
// words, others one. That limit is set by the single result register in the
// back end. An accepted input word passes the line store read, the work
// queue and the output register before its first result word is valid. The
// line store has one read-first port pair and holds one source row of
// MAX_SEGMENTS runs; it is not cleared after reset, so the first row after
// reset must be a band's first row (start_of_frame does this). The work
// queue of QUEUE_DEPTH entries lets the input side keep taking words while
// a result word waits to be taken. Configuration registers are to be written
// by the user only while the block is idle; it is not enforced. Index 0 sets
// rows per band (values below two act as two), index 1 sets six-pixel runs
// per line (zero acts as one, values above MAX_SEGMENTS are clamped).
`default_nettype none

module rgb565_band_upscaler_top
  import rbu_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  rbu_in_if.sink                in_ch,
  rbu_out_if.source             out_ch
);

  // Classified work from the front end into the queue.
  logic  push_valid, push_ready;
  work_t push_work;

  // Head of the queue as seen by the back end.
  logic  head_valid, head_pop;
  work_t head_work;

  rbu_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_work  (push_work)
  );

  rbu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_work  (push_work),
    .head_valid (head_valid),
    .pop        (head_pop),
    .head_work  (head_work)
  );

  rbu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_work  (head_work),
    .pop        (head_pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// File: hw/rtl/rbu_checker.sv
// ---------------------------------------------------------------------------
// RGB565 band upscaler port checker
// Concurrent checks on the top level's result channel, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rgb565_band_upscaler_top_macros.svh"

module rbu_checker
  import rbu_pkg::*;
(
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [OUT_PIXELS*PIX_W+ROW_W:0] out_word,
  input logic [ROW_W-1:0]                out_dest_row,
  input logic                            out_last
);

  // A stalled result word stays offered and unchanged.
  `RBU_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid)
  `RBU_ASSERT_HOLD(a_out_word_holds, out_valid && !out_ready, out_word)

  // Only the vertical average of a band's last row is followed by another
  // word of the same run, and that row is never the first nor the fourth.
  `RBU_ASSERT_IMPL(a_split_row, out_valid && !out_last,
                   out_dest_row == 2'd1 || out_dest_row == 2'd2)

  // Reset leaves no result word pending.
  `RBU_ASSERT_RESET(a_reset_empty, !out_valid)

endmodule

bind rgb565_band_upscaler_top rbu_checker u_rbu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_word     ({out_ch.pixel_out_7, out_ch.pixel_out_6, out_ch.pixel_out_5,
                  out_ch.pixel_out_4, out_ch.pixel_out_3, out_ch.pixel_out_2,
                  out_ch.pixel_out_1, out_ch.pixel_out_0, out_ch.dest_row,
                  out_ch.last_of_run}),
  .out_dest_row (out_ch.dest_row),
  .out_last     (out_ch.last_of_run)
);

`default_nettype wire
